### src/polyev_pkg.sv
package polyev_pkg;

  localparam int unsigned NUM_COEFFS = 8;
  localparam int unsigned COEF_REGS  = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic signed [DATA_W-1:0] Q_ONE    = DATA_W'(1) << FRAC_W;
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_W - 1);

  typedef logic [COEF_REGS-1:0][DATA_W-1:0] coef_arr_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] power;
    logic signed [DATA_W-1:0] sum;
    logic                     sat;
  } link_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } sat_word_t;

  function automatic sat_word_t clamp_word(input logic signed [PROD_W-1:0] r);
    logic [PROD_W-DATA_W:0] hi;
    sat_word_t              res;
    hi      = r[PROD_W-1:DATA_W-1];
    res.sat = !((&hi) || !(|hi));
    if (res.sat) begin
      res.val = r[PROD_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      res.val = r[DATA_W-1:0];
    end
    return res;
  endfunction

  function automatic sat_word_t rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + HALF_LSB) >>> FRAC_W;
    return clamp_word(r);
  endfunction

  function automatic sat_word_t add_sat(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    sat_word_t              res;
    s       = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    res.sat = s[DATA_W] != s[DATA_W-1];
    if (res.sat) begin
      res.val = s[DATA_W] ? WORD_MIN : WORD_MAX;
    end else begin
      res.val = s[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

### src/polynomial_evaluator.sv
// Channel  | Direction | Handshake                   | Payload
// x        | in        | x_valid_i / x_ready_o       | x_value_i
// y        | out       | y_valid_o / y_ready_i       | y_value_o, saturated_o
// cfg      | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the chain is held; each then passes through every cell to the output.
// Each cell of the chain has a multiply stage and a round/sum stage.
// Reset clears all coefficients to zero and empties the chain.
// A result not taken holds the whole chain, and x_ready_o drops until the transfer.
// Configuration writes are always taken; writes to indexes past the last register are dropped.
module polynomial_evaluator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 x_valid_i,
  output logic                                 x_ready_o,
  input  logic signed [polyev_pkg::DATA_W-1:0] x_value_i,
  output logic                                 y_valid_o,
  input  logic                                 y_ready_i,
  output logic signed [polyev_pkg::DATA_W-1:0] y_value_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [polyev_pkg::DATA_W-1:0]        cfg_data_i
);
  import polyev_pkg::*;

  coef_arr_t coefs;
  link_t     link [NUM_COEFFS+1];
  logic      en;

  assign en        = !link[NUM_COEFFS].valid || y_ready_i;
  assign x_ready_o = en;

  assign link[0].valid = x_valid_i;
  assign link[0].x     = x_value_i;
  assign link[0].power = Q_ONE;
  assign link[0].sum   = '0;
  assign link[0].sat   = 1'b0;

  polyev_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coefs)
  );

  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_cell
    polyev_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .last_i (k == NUM_COEFFS - 1),
      .coef_i (signed'(coefs[k])),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  assign y_valid_o   = link[NUM_COEFFS].valid;
  assign y_value_o   = link[NUM_COEFFS].sum;
  assign saturated_o = link[NUM_COEFFS].sat;

`ifndef SYNTH
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_valid_o && !y_ready_i |-> !x_ready_o)
    else $error("input taken while the result waits");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_valid_o && !y_ready_i |=> y_valid_o && $stable(y_value_o) && $stable(saturated_o))
    else $error("waiting result changed before transfer");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !y_valid_o |-> x_ready_o)
    else $error("input refused with no result waiting");
`endif

endmodule

### src/polyev_coef_regs.sv
module polyev_coef_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [polyev_pkg::DATA_W-1:0]        cfg_data_i,
  output polyev_pkg::coef_arr_t                coef_o
);
  import polyev_pkg::*;

  coef_arr_t coef_q;

  assign cfg_ready_o = 1'b1;
  assign coef_o      = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(COEF_REGS))) begin
      coef_q[cfg_index_i[$clog2(COEF_REGS)-1:0]] <= cfg_data_i;
    end
  end

`ifndef SYNTH
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == '0) |=> coef_o[0] == $past(cfg_data_i))
    else $error("coefficient zero not taken on transfer");

  a_drop_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i || (cfg_index_i >= CFG_IDX_W'(COEF_REGS)) |=> $stable(coef_o))
    else $error("coefficients changed without a valid transfer");

  a_one_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == CFG_IDX_W'(1)) |=> $stable(coef_o[0]))
    else $error("write to coefficient one disturbed coefficient zero");
`endif

endmodule

### src/polyev_cell.sv
module polyev_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               last_i,
  input  logic signed [polyev_pkg::DATA_W-1:0] coef_i,
  input  polyev_pkg::link_t                  link_i,
  output polyev_pkg::link_t                  link_o
);
  import polyev_pkg::*;

  logic                     a_valid_q;
  logic signed [DATA_W-1:0] a_x_q;
  logic signed [DATA_W-1:0] a_sum_q;
  logic                     a_sat_q;
  logic signed [PROD_W-1:0] a_pt_q;
  logic signed [PROD_W-1:0] a_pp_q;
  logic signed [PROD_W-1:0] a_pt_d;
  logic signed [PROD_W-1:0] a_pp_d;

  sat_word_t pow_w;
  sat_word_t term_w;
  sat_word_t acc_w;
  link_t     link_d;
  link_t     link_q;

  assign a_pt_d = coef_i * link_i.power;
  assign a_pp_d = link_i.power * link_i.x;

  always_comb begin
    pow_w        = rnd_sat(a_pp_q);
    term_w       = rnd_sat(a_pt_q);
    acc_w        = add_sat(a_sum_q, term_w.val);
    link_d.valid = a_valid_q;
    link_d.x     = a_x_q;
    link_d.power = pow_w.val;
    link_d.sum   = acc_w.val;
    link_d.sat   = a_sat_q | term_w.sat | acc_w.sat | (pow_w.sat & !last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      link_q    <= '0;
    end else if (en_i) begin
      a_valid_q <= link_i.valid;
      link_q    <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q   <= link_i.x;
      a_sum_q <= link_i.sum;
      a_sat_q <= link_i.sat;
      a_pt_q  <= a_pt_d;
      a_pp_q  <= a_pp_d;
    end
  end

  assign link_o = link_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(a_valid_q) && $stable(link_o.valid))
    else $error("cell advanced while the chain was held");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && a_valid_q |=> link_o.valid)
    else $error("item lost between cell stages");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && a_valid_q && a_sat_q |=> link_o.sat)
    else $error("saturation flag dropped inside cell");
`endif

endmodule

### tb/polynomial_evaluator_tb.sv
module polynomial_evaluator_tb;
  import polyev_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_COEFFS + 4;
  localparam int unsigned PER_SETTING  = 156;
  localparam int unsigned N_DIR        = 35;
  localparam int SEND_IDLE [3] = '{8, 67, 0};
  localparam int RECV_IDLE [3] = '{67, 8, 0};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF0     = 4'd0,
    REG_COEF1     = 4'd1,
    REG_COEF2     = 4'd2,
    REG_COEF3     = 4'd3,
    REG_COEF4     = 4'd4,
    REG_COEF5     = 4'd5,
    REG_COEF6     = 4'd6,
    REG_COEF7     = 4'd7,
    REG_UNUSED_LO = 4'd8,
    REG_UNUSED_HI = 4'd15
  } reg_idx_e;

  typedef enum logic [1:0] {ROW_WRITE, ROW_EVAL, ROW_EVAL_KNOWN} row_kind_e;
  typedef enum int {COEF_FULL, COEF_SMALL, COEF_EXTREME, COEF_MIXED} coef_mode_e;

  typedef struct packed {
    row_kind_e         kind;
    reg_idx_e          idx;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] y_lit;
    logic              sat_lit;
  } dir_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     sat;
  } poly_res_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h7FFF_FFFF, 32'h0000_0000, 1'b1},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h8000_0000, 32'h0000_0000, 1'b1},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF0,     32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE,      REG_COEF1,     32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0001_0000, 32'h7FFF_FFFF, 1'b1},
    '{ROW_WRITE,      REG_COEF0,     32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF1,     32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0001_0000, 32'h8000_0000, 1'b1},
    '{ROW_WRITE,      REG_UNUSED_LO, 32'h1234_5678, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_UNUSED_HI, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_0000, 32'h8000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF0,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF1,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF2,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF3,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF4,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF5,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF6,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF7,     32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0001_0000, 32'h0008_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_0000, 32'h0001_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'hFFFF_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0002_0000, 32'h00FF_0000, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_8000, 32'h0001_FE00, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0000_0001, 32'h0001_0001, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0100_0000, 32'h7FFF_FFFF, 1'b1},
    '{ROW_EVAL_KNOWN, REG_COEF0,     32'h0004_0000, 32'h5555_0000, 1'b0},
    '{ROW_EVAL,       REG_COEF0,     32'hFF00_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEF0,     32'hFFFF_8000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF7,     32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEF0,     32'h0002_0000, 32'h0000_0000, 1'b0}
  };

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     x_valid   = 1'b0;
  logic signed [DATA_W-1:0] x_value   = '0;
  logic                     y_ready   = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;
  logic                     x_ready;
  logic                     y_valid;
  logic signed [DATA_W-1:0] y_value;
  logic                     y_sat;
  logic                     cfg_ready;

  logic signed [DATA_W-1:0] coef_shadow [COEF_REGS];
  poly_res_t                expected_q [$];
  int unsigned              cycle_count   = 0;
  int unsigned              fail_count    = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;

  polynomial_evaluator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .x_valid_i   (x_valid),
    .x_ready_o   (x_ready),
    .x_value_i   (x_value),
    .y_valid_o   (y_valid),
    .y_ready_i   (y_ready),
    .y_value_o   (y_value),
    .saturated_o (y_sat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic signed [DATA_W-1:0] clip_word(input longint v, inout logic flag);
    if (v > longint'(WORD_MAX)) begin
      flag = 1'b1;
      return WORD_MAX;
    end
    if (v < longint'(WORD_MIN)) begin
      flag = 1'b1;
      return WORD_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] round_mul(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b,
                                                         inout logic flag);
    longint p;
    p = longint'(a) * longint'(b) + longint'(HALF_LSB);
    return clip_word(p >>> FRAC_W, flag);
  endfunction

  function automatic poly_res_t eval_poly(input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] pw;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] term;
    logic                     flag;
    poly_res_t                r;
    pw   = Q_ONE;
    acc  = '0;
    flag = 1'b0;
    for (int k = 0; k < NUM_COEFFS; k++) begin
      if (k > 0) pw = round_mul(pw, x, flag);
      term = round_mul(coef_shadow[k], pw, flag);
      acc  = clip_word(longint'(acc) + longint'(term), flag);
    end
    r.y   = acc;
    r.sat = flag;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_coef(input coef_mode_e m);
    case (m)
      COEF_FULL: begin
        return $urandom;
      end
      COEF_SMALL: begin
        return $urandom_range(0, 32'h40000) - 32'h20000;
      end
      default: begin
        case ($urandom_range(4))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return Q_ONE;
          3: return -Q_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_point();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return $urandom;
    if (r < 25) begin
      case ($urandom_range(6))
        0: return '0;
        1: return Q_ONE;
        2: return -Q_ONE;
        3: return WORD_MAX;
        4: return WORD_MIN;
        5: return 1;
        default: return -1;
      endcase
    end
    return $urandom_range(0, 32'h80000) - 32'h40000;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 200) $display("[cycle %0d] mismatch: %s", cycle_count, what);
    fail_count++;
  endtask

  task automatic send_point(input logic signed [DATA_W-1:0] x, input poly_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      x_valid <= 1'b0;
      @(posedge clk);
    end
    x_valid <= 1'b1;
    x_value <= x;
    @(posedge clk);
    while (!x_ready) @(posedge clk);
    expected_q = {expected_q, want};
  endtask

  task automatic send_point_random();
    logic signed [DATA_W-1:0] x;
    x = pick_point();
    send_point(x, eval_poly(x));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < COEF_REGS) coef_shadow[idx] = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_block();
    x_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs(input coef_mode_e mode);
    coef_mode_e m;
    if ($urandom_range(1)) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
    end
    for (int k = 0; k < COEF_REGS; k++) begin
      m = (mode == COEF_MIXED) ? coef_mode_e'($urandom_range(COEF_EXTREME)) : mode;
      write_reg(CFG_IDX_W'(k), pick_coef(m));
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      y_ready <= 1'b0;
    end else begin
      y_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    poly_res_t want;
    if (rst_n && y_valid && y_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=%h sat=%b", y_value, y_sat));
      end else begin
        want = expected_q.pop_front();
        if (y_value !== want.y) begin
          report_mismatch($sformatf("y_value %h, want %h", y_value, want.y));
        end
        if (y_sat !== want.sat) begin
          report_mismatch($sformatf("saturated %b, want %b", y_sat, want.sat));
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t  row;
    poly_res_t want;
    for (int k = 0; k < COEF_REGS; k++) coef_shadow[k] = '0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      case (row.kind)
        ROW_WRITE: begin
          drain_block();
          write_reg(row.idx, row.word);
        end
        ROW_EVAL_KNOWN: begin
          want.y   = row.y_lit;
          want.sat = row.sat_lit;
          send_point(row.word, want);
        end
        default: begin
          send_point(row.word, eval_poly(row.word));
        end
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      for (int s = 0; s < 4; s++) begin
        drain_block();
        load_coefs(coef_mode_e'(s));
        repeat (PER_SETTING) begin
          send_point_random();
        end
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/polyev_pkg.sv
src/polyev_coef_regs.sv
src/polyev_cell.sv
src/polynomial_evaluator.sv
tb/polynomial_evaluator_tb.sv
